[hdl/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define NPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scheduler assertion failed");

// Clocked assertion that also holds during reset.
`define NPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("scheduler assertion failed");

`endif

[hdl/nps_pkg.sv]
// Shared constants, types and the job ordering function of the scheduler.
// Depends on nothing.
package nps_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W       = 48;
    localparam int TIME_W      = 25;

    localparam logic STATUS_DISPATCHED = 1'b0;
    localparam logic STATUS_REJECTED   = 1'b1;

    // Entry layout: arrival [47:24], burst [23:8], priority [7:0].
    typedef logic [ENT_W-1:0] t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SCAN_END,
        S_DISP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic             clear;
        logic             cand_vld;
        logic [IDX_W-1:0] cand_idx;
    } t_scan_ctl;

    // True when entry a is served before entry b.
    function automatic logic beats(input t_entry a, input t_entry b);
        logic res;
        if (a[7:0] != b[7:0]) begin
            res = (a[7:0] > b[7:0]);
        end else if (a[23:8] != b[23:8]) begin
            res = (a[23:8] < b[23:8]);
        end else begin
            res = (a[47:24] < b[47:24]);
        end
        return res;
    endfunction
endpackage

[hdl/nps_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[hdl/nps_select.sv]
// Running best-entry selector fed one queue entry per cycle during a scan.
// Depends on nps_pkg.
module nps_select (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nps_pkg::t_scan_ctl       i_ctl,
    input  nps_pkg::t_entry          i_cand,
    output logic                     o_best_vld,
    output logic [nps_pkg::IDX_W-1:0] o_best_idx,
    output nps_pkg::t_entry          o_best_ent
);
    import nps_pkg::*;

    logic             r_best_vld;
    logic [IDX_W-1:0] r_best_idx;
    t_entry           r_best_ent;

    // Slots arrive in ascending order, so a full tie keeps the lower slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_best_vld <= 1'b0;
        end else if (i_ctl.cand_vld && (!r_best_vld || beats(i_cand, r_best_ent))) begin
            r_best_vld <= 1'b1;
        end
        if (i_ctl.cand_vld && (!r_best_vld || beats(i_cand, r_best_ent))) begin
            r_best_idx <= i_ctl.cand_idx;
            r_best_ent <= i_cand;
        end
    end

    assign o_best_vld = r_best_vld;
    assign o_best_idx = r_best_idx;
    assign o_best_ent = r_best_ent;
endmodule

[hdl/nonpreemptive_priority_scheduler.sv]
// Non-preemptive priority scheduler: a job is taken when start is high and
// busy is low. Every dispatch scans the ready queue memory one slot a cycle
// and then takes the best waiting entry out of the queue. Results appear
// one per strobe and cannot be held off; the final result of a job carries
// o_last_of_run, which is why each result is shown once the next one, or the
// end of the job's work, is known.
// Depends on nps_pkg, nps_ram, nps_select and assert_macros.svh.
`include "assert_macros.svh"
module nonpreemptive_priority_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [23:0] i_arrival_time,
    input  logic [15:0] i_burst_length,
    input  logic [7:0]  i_job_priority,
    input  logic        i_last_job,
    output logic        o_strobe,
    output logic [23:0] o_job_arrival,
    output logic [15:0] o_job_burst,
    output logic [7:0]  o_job_level,
    output logic [24:0] o_start_time,
    output logic [24:0] o_waiting_time,
    output logic        o_status,
    output logic        o_last_of_run
);
    import nps_pkg::*;

    t_state r_state, n_state;
    logic [23:0] r_arr, n_arr;
    logic [15:0] r_burst, n_burst;
    logic [7:0]  r_prio, n_prio;
    logic        r_last, n_last;
    logic        r_drain, n_drain;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic        r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [QUEUE_DEPTH-1:0] r_valid, n_valid;
    logic [CNT_W-1:0] r_count, n_count;
    logic [TIME_W-1:0] r_free, n_free;

    logic        r_pend_vld, n_pend_vld;
    logic [23:0] r_pend_arr, n_pend_arr;
    logic [15:0] r_pend_burst, n_pend_burst;
    logic [7:0]  r_pend_prio, n_pend_prio;
    logic [TIME_W-1:0] r_pend_start, n_pend_start;
    logic [TIME_W-1:0] r_pend_wait, n_pend_wait;
    logic        r_pend_status, n_pend_status;

    logic        r_strobe, n_strobe;
    logic [23:0] r_o_arr, n_o_arr;
    logic [15:0] r_o_burst, n_o_burst;
    logic [7:0]  r_o_prio, n_o_prio;
    logic [TIME_W-1:0] r_o_start, n_o_start;
    logic [TIME_W-1:0] r_o_wait, n_o_wait;
    logic        r_o_status, n_o_status;
    logic        r_o_last, n_o_last;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             rd_en;
    t_entry           rd_data;
    t_scan_ctl        scan_ctl;
    logic             best_vld;
    logic [IDX_W-1:0] best_idx;
    t_entry           best_ent;
    logic [IDX_W-1:0] free_slot;
    logic [CNT_W-1:0] limit;
    logic             emit_new;
    logic [23:0]      new_arr;
    logic [15:0]      new_burst;
    logic [7:0]       new_prio;
    logic [TIME_W-1:0] new_start;
    logic [TIME_W-1:0] new_wait;
    logic             new_status;
    logic [TIME_W-1:0] disp_start;
    logic [TIME_W:0]   disp_sum;

    nps_ram #(
        .WIDTH(ENT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_idx),
        .o_rd_data(rd_data)
    );

    nps_select u_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_cand    (rd_data),
        .o_best_vld(best_vld),
        .o_best_idx(best_idx),
        .o_best_ent(best_ent)
    );

    // Lowest free slot.
    always_comb begin
        free_slot = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = IDX_W'(i);
            end
        end
    end

    assign limit      = r_last ? CNT_W'(QUEUE_DEPTH) : CNT_W'(QUEUE_DEPTH - 1);
    assign disp_start = (r_free > {1'b0, best_ent[47:24]}) ? r_free
                                                           : {1'b0, best_ent[47:24]};
    assign disp_sum   = {1'b0, disp_start} + {{(TIME_W - 15){1'b0}}, best_ent[23:8]};

    always_comb begin
        n_state    = r_state;
        n_arr      = r_arr;
        n_burst    = r_burst;
        n_prio     = r_prio;
        n_last     = r_last;
        n_drain    = r_drain;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_valid    = r_valid;
        n_count    = r_count;
        n_free     = r_free;
        wr_en      = 1'b0;
        wr_addr    = free_slot;
        wr_data    = {r_arr, r_burst, r_prio};
        rd_en      = 1'b0;
        scan_ctl.clear    = 1'b0;
        scan_ctl.cand_vld = r_rd_vld && r_valid[r_rd_idx];
        scan_ctl.cand_idx = r_rd_idx;
        emit_new   = 1'b0;
        new_arr    = r_arr;
        new_burst  = r_burst;
        new_prio   = r_prio;
        new_start  = '0;
        new_wait   = '0;
        new_status = STATUS_REJECTED;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_arr   = i_arrival_time;
                    n_burst = i_burst_length;
                    n_prio  = i_job_priority;
                    n_last  = i_last_job;
                    n_drain = 1'b0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((r_count != '0) && (r_drain || ({1'b0, r_arr} > r_free))) begin
                    n_idx          = '0;
                    scan_ctl.clear = 1'b1;
                    n_state        = S_SCAN;
                end else if (!r_drain) begin
                    if (r_count >= limit) begin
                        emit_new = 1'b1;
                    end else begin
                        wr_en              = 1'b1;
                        n_valid[free_slot] = 1'b1;
                        n_count            = r_count + CNT_W'(1);
                    end
                    if (r_last) begin
                        n_drain = 1'b1;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_valid = '0;
                    n_free  = '0;
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                rd_en    = 1'b1;
                n_rd_vld = 1'b1;
                n_rd_idx = r_idx;
                if (r_idx == IDX_W'(QUEUE_DEPTH - 1)) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_SCAN_END: begin
                n_state = S_DISP;
            end
            S_DISP: begin
                n_free            = disp_sum[TIME_W] ? {TIME_W{1'b1}} : disp_sum[TIME_W-1:0];
                n_valid[best_idx] = 1'b0;
                n_count           = r_count - CNT_W'(1);
                emit_new          = 1'b1;
                new_arr           = best_ent[47:24];
                new_burst         = best_ent[23:8];
                new_prio          = best_ent[7:0];
                new_start         = disp_start;
                new_wait          = disp_start - {1'b0, best_ent[47:24]};
                new_status        = STATUS_DISPATCHED;
                n_state           = S_CHECK;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A new result waits in the pending slot until the next result or the end
    // of the job shows whether it is the final one.
    always_comb begin
        n_pend_vld    = r_pend_vld;
        n_pend_arr    = r_pend_arr;
        n_pend_burst  = r_pend_burst;
        n_pend_prio   = r_pend_prio;
        n_pend_start  = r_pend_start;
        n_pend_wait   = r_pend_wait;
        n_pend_status = r_pend_status;
        n_strobe      = 1'b0;
        n_o_arr       = r_pend_arr;
        n_o_burst     = r_pend_burst;
        n_o_prio      = r_pend_prio;
        n_o_start     = r_pend_start;
        n_o_wait      = r_pend_wait;
        n_o_status    = r_pend_status;
        n_o_last      = 1'b0;
        if (emit_new) begin
            n_strobe      = r_pend_vld;
            n_pend_vld    = 1'b1;
            n_pend_arr    = new_arr;
            n_pend_burst  = new_burst;
            n_pend_prio   = new_prio;
            n_pend_start  = new_start;
            n_pend_wait   = new_wait;
            n_pend_status = new_status;
        end else if (r_state == S_FINISH) begin
            n_strobe   = r_pend_vld;
            n_o_last   = 1'b1;
            n_pend_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_vld   <= 1'b0;
            r_valid    <= '0;
            r_count    <= '0;
            r_free     <= '0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
            r_drain    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= n_rd_vld;
            r_valid    <= n_valid;
            r_count    <= n_count;
            r_free     <= n_free;
            r_pend_vld <= n_pend_vld;
            r_strobe   <= n_strobe;
            r_drain    <= n_drain;
        end
        r_arr         <= n_arr;
        r_burst       <= n_burst;
        r_prio        <= n_prio;
        r_last        <= n_last;
        r_idx         <= n_idx;
        r_rd_idx      <= n_rd_idx;
        r_pend_arr    <= n_pend_arr;
        r_pend_burst  <= n_pend_burst;
        r_pend_prio   <= n_pend_prio;
        r_pend_start  <= n_pend_start;
        r_pend_wait   <= n_pend_wait;
        r_pend_status <= n_pend_status;
        r_o_arr       <= n_o_arr;
        r_o_burst     <= n_o_burst;
        r_o_prio      <= n_o_prio;
        r_o_start     <= n_o_start;
        r_o_wait      <= n_o_wait;
        r_o_status    <= n_o_status;
        r_o_last      <= n_o_last;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_job_arrival  = r_o_arr;
    assign o_job_burst    = r_o_burst;
    assign o_job_level    = r_o_prio;
    assign o_start_time   = r_o_start;
    assign o_waiting_time = r_o_wait;
    assign o_status       = r_o_status;
    assign o_last_of_run  = r_o_last;

    `NPS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH))
    `NPS_ASSERT(a_count_matches, i_clk, i_rst_n, $countones(r_valid) == int'(r_count))
    `NPS_ASSERT(a_disp_has_best, i_clk, i_rst_n, (r_state == S_DISP) |-> best_vld)
    `NPS_ASSERT(a_strobe_from_work, i_clk, i_rst_n, o_strobe |-> $past(r_state != S_IDLE))
endmodule
